// ----- hw/rtl/wcrm_pkg.sv -----
// shared types, register map and constants of the waveform column row mapper
// used by wcrm_ctrl, wcrm_dp and waveform_column_row_mapper
`default_nettype none

package wcrm_pkg;

   // default parameter values
   localparam int MAX_CHANNELS_DEF = 8;
   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int ROW_BITS_DEF     = 12;

   // fixed field widths
   localparam int PLOT_W   = 12;
   localparam int WB_W     = 16;
   localparam int WH_W     = 16;
   localparam int GAIN_W   = 24;
   localparam int SCALE_W  = 16;
   localparam int SEL_W    = 4;
   localparam int CNT_W    = 4;
   localparam int CH_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PLOT_BOTTOM     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_BOTTOM   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_HEIGHT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AMPLITUDE_SCALE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_SELECT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNEL_COUNT   = 3'd6;

   // reset values
   localparam logic [PLOT_W-1:0]  RST_PLOT_BOTTOM     = 12'd100;
   localparam logic [WB_W-1:0]    RST_WINDOW_BOTTOM   = 16'h8000;
   localparam logic [WH_W-1:0]    RST_WINDOW_HEIGHT   = 16'hFFFF;
   localparam logic [GAIN_W-1:0]  RST_HEIGHT_GAIN     = 24'd99;
   localparam logic [SCALE_W-1:0] RST_AMPLITUDE_SCALE = 16'd256;
   localparam logic [SEL_W-1:0]   RST_CHANNEL_SELECT  = 4'hF;
   localparam logic [CNT_W-1:0]   RST_CHANNEL_COUNT   = 4'd1;

   typedef struct packed {
      logic [PLOT_W-1:0]  plot_bottom;
      logic [WB_W-1:0]    window_bottom;
      logic [WH_W-1:0]    window_height;
      logic [GAIN_W-1:0]  height_gain;
      logic [SCALE_W-1:0] amplitude_scale;
      logic [SEL_W-1:0]   channel_select;
      logic [CNT_W-1:0]   channel_count;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic       accept;     // item taken this cycle
      logic       start_map;  // latch result mode, clear unused rows
      logic       mul_scale;  // value times amplitude scale
      logic       clamp;      // offset, clamp, truncate
      logic       mul_gain;   // truncated value times height gain
      logic       row_write;  // subtract from plot bottom, store row
      logic [1:0] val_sel;    // which kept value is being mapped
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_mode;  // result being built is combined mode
   } stat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/wcrm_dp.sv -----
// datapath: per-column min/max accumulators, shared multiplier row mapping
// and the result registers; depends on wcrm_pkg
`default_nettype none

module wcrm_dp #(
   parameter int MAX_CHANNELS = wcrm_pkg::MAX_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = wcrm_pkg::SAMPLE_BITS_DEF,
   parameter int ROW_BITS     = wcrm_pkg::ROW_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  wcrm_pkg::cfg_type             cfg,
   input  wire  wcrm_pkg::cmd_type             cmd,
   output wcrm_pkg::stat_type                  stat,
   input  wire  signed [SAMPLE_BITS-1:0]       min_sample,
   input  wire  signed [SAMPLE_BITS-1:0]       max_sample,
   input  wire  [wcrm_pkg::CH_W-1:0]           channel_index,
   input  wire                                 last_channel,
   output logic signed [ROW_BITS:0]            row_first,
   output logic signed [ROW_BITS:0]            row_second,
   output logic signed [ROW_BITS:0]            row_third,
   output logic signed [ROW_BITS:0]            row_fourth,
   output logic                                combined_mode
);
   import wcrm_pkg::*;

   localparam int OPA_W = ((SAMPLE_BITS > WH_W) ? SAMPLE_BITS : WH_W) + 1;
   localparam int OPB_W = GAIN_W + 1;
   localparam int P_W   = OPA_W + OPB_W;
   localparam int D_W   = GAIN_W + 2;
   localparam logic [7:0] MAX_CH_V = 8'(MAX_CHANNELS);
   localparam logic signed [D_W-1:0] ROW_MAX = D_W'((1 << ROW_BITS) - 1);
   localparam logic signed [D_W-1:0] ROW_MIN = -ROW_MAX - D_W'(1);

   // accumulators
   logic signed [SAMPLE_BITS-1:0] min_min_ff, min_min_in;
   logic signed [SAMPLE_BITS-1:0] max_min_ff, max_min_in;
   logic signed [SAMPLE_BITS-1:0] min_max_ff, min_max_in;
   logic signed [SAMPLE_BITS-1:0] max_max_ff, max_max_in;
   logic started_ff, started_in;

   logic [7:0] cnt_eff;
   logic       single;

   // mapping
   logic signed [SAMPLE_BITS-1:0] map_val;
   logic signed [SAMPLE_BITS-1:0] inner_hi, inner_lo;
   logic signed [OPA_W-1:0]       mul_a;
   logic signed [OPB_W-1:0]       mul_b;
   logic signed [P_W-1:0]         prod_ff, prod_in;
   logic [WH_W-1:0]               t_ff, t_in;
   logic signed [P_W:0]           b_val, wb_sh, hi_b;
   logic [GAIN_W-1:0]             p_val;
   logic signed [D_W-1:0]         diff;
   logic signed [ROW_BITS:0]      row_val;
   logic signed [ROW_BITS:0]      row_ff [4];
   logic out_mode_ff, out_mode_in;

   always_comb begin
      cnt_eff = (8'(cfg.channel_count) > MAX_CH_V) ? MAX_CH_V : 8'(cfg.channel_count);
      single  = !cfg.channel_select[SEL_W-1] &&
                (8'(cfg.channel_select) < cnt_eff);
   end

   always_comb begin
      min_min_in = min_min_ff;
      max_min_in = max_min_ff;
      min_max_in = min_max_ff;
      max_max_in = max_max_ff;
      started_in = started_ff;
      if (cmd.accept) begin
         if (single) begin
            if (cfg.channel_select[CH_W-1:0] == channel_index) begin
               min_min_in = min_sample;
               max_max_in = max_sample;
            end
         end else if (!started_ff) begin
            min_min_in = min_sample;
            max_min_in = min_sample;
            min_max_in = max_sample;
            max_max_in = max_sample;
            started_in = 1'b1;
         end else begin
            if (min_sample < min_min_ff) min_min_in = min_sample;
            if (min_sample > max_min_ff) max_min_in = min_sample;
            if (max_sample < min_max_ff) min_max_in = max_sample;
            if (max_sample > max_max_ff) max_max_in = max_sample;
         end
         if (last_channel) begin
            started_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_min_ff <= '0;
         max_min_ff <= '0;
         min_max_ff <= '0;
         max_max_ff <= '0;
         started_ff <= 1'b0;
      end else begin
         min_min_ff <= min_min_in;
         max_min_ff <= max_min_in;
         min_max_ff <= min_max_in;
         max_max_ff <= max_max_in;
         started_ff <= started_in;
      end
   end

   // the mode of the closing item decides the result format
   logic item_mode_ff, item_mode_in;
   assign item_mode_in = cmd.accept ? !single : item_mode_ff;
   assign out_mode_in  = cmd.start_map ? item_mode_ff : out_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_mode_ff <= 1'b0;
         out_mode_ff  <= 1'b0;
      end else begin
         item_mode_ff <= item_mode_in;
         out_mode_ff  <= out_mode_in;
      end
   end

   assign stat.out_mode = out_mode_ff;

   // inner pair swaps when the ranges cross
   always_comb begin
      if (min_max_ff < max_min_ff) begin
         inner_hi = max_min_ff;
         inner_lo = min_max_ff;
      end else begin
         inner_hi = min_max_ff;
         inner_lo = max_min_ff;
      end
      if (out_mode_ff) begin
         unique case (cmd.val_sel)
            2'd0:    map_val = max_max_ff;
            2'd1:    map_val = inner_hi;
            2'd2:    map_val = inner_lo;
            default: map_val = min_min_ff;
         endcase
      end else begin
         map_val = cmd.val_sel[0] ? max_max_ff : min_min_ff;
      end
   end

   // one shared multiplier for both products
   always_comb begin
      if (cmd.mul_gain) begin
         mul_a = $signed(OPA_W'(t_ff));
         mul_b = $signed({1'b0, cfg.height_gain});
      end else begin
         mul_a = OPA_W'(map_val);
         mul_b = $signed(OPB_W'(cfg.amplitude_scale));
      end
      prod_in = prod_ff;
      if (cmd.mul_scale || cmd.mul_gain) begin
         prod_in = mul_a * mul_b;
      end
   end

   always_comb begin
      wb_sh = $signed((P_W+1)'($signed(cfg.window_bottom))) <<< 8;
      hi_b  = $signed((P_W+1)'({cfg.window_height, 8'd0}));
      b_val = (P_W+1)'(prod_ff) - wb_sh;
      t_in  = t_ff;
      if (cmd.clamp) begin
         priority if (b_val < 0) begin
            t_in = '0;
         end else if (b_val > hi_b) begin
            t_in = cfg.window_height;
         end else begin
            t_in = b_val[WH_W+7:8];
         end
      end
   end

   always_comb begin
      p_val = prod_ff[GAIN_W+15:16];
      diff  = $signed(D_W'(cfg.plot_bottom)) - $signed(D_W'(p_val));
      priority if (diff < ROW_MIN) begin
         row_val = ROW_MIN[ROW_BITS:0];
      end else if (diff > ROW_MAX) begin
         row_val = ROW_MAX[ROW_BITS:0];
      end else begin
         row_val = diff[ROW_BITS:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      t_ff    <= t_in;
      if (cmd.start_map && !item_mode_ff) begin
         row_ff[2] <= '0;
         row_ff[3] <= '0;
      end
      if (cmd.row_write) begin
         row_ff[cmd.val_sel] <= row_val;
      end
   end

   assign row_first     = row_ff[0];
   assign row_second    = row_ff[1];
   assign row_third     = row_ff[2];
   assign row_fourth    = row_ff[3];
   assign combined_mode = out_mode_ff;

   a_clamp_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.clamp |=> t_ff <= cfg.window_height)
      else $error("clamped value above window height");

   a_mode_only_at_start: assert property (@(posedge clock) disable iff (reset)
      !cmd.start_map |=> $stable(out_mode_ff))
      else $error("result mode changed outside map start");

   a_single_zero_rows: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_map && !item_mode_ff) |=> (row_ff[2] == '0 && row_ff[3] == '0))
      else $error("unused rows not cleared in single mode");

endmodule

`default_nettype wire

// ----- hw/rtl/wcrm_ctrl.sv -----
// controller: item intake, four-step mapping sequence per kept value and
// result valid handling; depends on wcrm_pkg
`default_nettype none

module wcrm_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   input  wire                 req_tlast,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   input  wire  wcrm_pkg::stat_type stat,
   output wcrm_pkg::cmd_type   cmd
);
   import wcrm_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WAIT  = 3'd1;
   localparam logic [2:0] S_MUL1  = 3'd2;
   localparam logic [2:0] S_CLAMP = 3'd3;
   localparam logic [2:0] S_MUL2  = 3'd4;
   localparam logic [2:0] S_ROW   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] val_ff, val_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept, slot_free, last_val;

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign last_val  = stat.out_mode ? (val_ff == 2'd3) : (val_ff == 2'd1);

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.val_sel  = val_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = accept;
            if (accept && req_tlast) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // rows are rebuilt in place, so the previous result must be gone
            if (slot_free) begin
               cmd.start_map = 1'b1;
               val_in        = 2'd0;
               state_in      = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_scale = 1'b1;
            state_in      = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_gain = 1'b1;
            state_in     = S_ROW;
         end
         S_ROW: begin
            cmd.row_write = 1'b1;
            if (last_val) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               val_in   = val_ff + 2'd1;
               state_in = S_MUL1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         val_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         val_ff       <= val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_valid_after_row: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_ROW)
      else $error("result raised outside the last row step");

   a_map_starts_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start_map |=> !rsp_valid_ff)
      else $error("mapping started while a result was still held");

   a_single_two_values: assert property (@(posedge clock) disable iff (reset)
      (!stat.out_mode && (state_ff == S_MUL1 || state_ff == S_ROW)) |-> val_ff <= 2'd1)
      else $error("single mode mapped more than two values");

   a_no_intake_mapping: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |=> !cmd.accept)
      else $error("item taken while a column was waiting to be mapped");

endmodule

`default_nettype wire

// ----- hw/rtl/waveform_column_row_mapper.sv -----
// Waveform column row mapper, top level: configuration registers, controller
// and datapath. Depends on wcrm_pkg, wcrm_ctrl and wcrm_dp.
//
// Usage: each req item carries one channel's min and max sample of the current
// display column; req_tlast marks the column's last channel. Non-closing items
// are taken one per cycle. After a closing item the block maps the kept values
// to pixel rows through one shared multiplier, each value passing through a
// scale multiply, offset and clamp, gain multiply and row subtract; it maps two
// values in single-channel mode and four in combined mode, and req_tready stays
// low meanwhile. rsp_tuser high means all four rows are valid. A held result
// does not stop intake of the next column; only the start of the next mapping
// waits until the result is taken. The csr channel writes one register per
// cycle and is always ready; write it only while no column is being mapped.
// Reset (synchronous, active high) loads the register defaults, clears the
// accumulators and drops rsp_tvalid.
`default_nettype none

module waveform_column_row_mapper #(
   parameter int MAX_CHANNELS = wcrm_pkg::MAX_CHANNELS_DEF,
   parameter int SAMPLE_BITS  = wcrm_pkg::SAMPLE_BITS_DEF,
   parameter int ROW_BITS     = wcrm_pkg::ROW_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // min_sample, max_sample, channel_index (from bit 0 up)
   input  wire  [((2*SAMPLE_BITS+3+7)/8)*8-1:0]  req_tdata,
   input  wire                                   req_tlast,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // row_first, row_second, row_third, row_fourth (from bit 0 up)
   output logic [((4*(ROW_BITS+1)+7)/8)*8-1:0]   rsp_tdata,
   // combined_mode
   output logic                                  rsp_tuser,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [wcrm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [wcrm_pkg::CSR_DATA_W-1:0]       csr_data
);
   import wcrm_pkg::*;

   localparam int REQ_W = ((2*SAMPLE_BITS+3+7)/8)*8;
   localparam int RSP_W = ((4*(ROW_BITS+1)+7)/8)*8;
   localparam int ROWS_W = 4*(ROW_BITS+1);

   cfg_type  cfg_ff, cfg_in;
   cmd_type  cmd;
   stat_type stat;

   logic signed [SAMPLE_BITS-1:0] min_sample, max_sample;
   logic [CH_W-1:0]               channel_index;
   logic signed [ROW_BITS:0]      row_first, row_second, row_third, row_fourth;
   logic                          combined_mode;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PLOT_BOTTOM:     cfg_in.plot_bottom     = csr_data[PLOT_W-1:0];
            REG_WINDOW_BOTTOM:   cfg_in.window_bottom   = csr_data[WB_W-1:0];
            REG_WINDOW_HEIGHT:   cfg_in.window_height   = csr_data[WH_W-1:0];
            REG_HEIGHT_GAIN:     cfg_in.height_gain     = csr_data[GAIN_W-1:0];
            REG_AMPLITUDE_SCALE: cfg_in.amplitude_scale = csr_data[SCALE_W-1:0];
            REG_CHANNEL_SELECT:  cfg_in.channel_select  = csr_data[SEL_W-1:0];
            REG_CHANNEL_COUNT:   cfg_in.channel_count   = csr_data[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.plot_bottom     <= RST_PLOT_BOTTOM;
         cfg_ff.window_bottom   <= RST_WINDOW_BOTTOM;
         cfg_ff.window_height   <= RST_WINDOW_HEIGHT;
         cfg_ff.height_gain     <= RST_HEIGHT_GAIN;
         cfg_ff.amplitude_scale <= RST_AMPLITUDE_SCALE;
         cfg_ff.channel_select  <= RST_CHANNEL_SELECT;
         cfg_ff.channel_count   <= RST_CHANNEL_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign min_sample    = req_tdata[SAMPLE_BITS-1:0];
   assign max_sample    = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign channel_index = req_tdata[2*SAMPLE_BITS+CH_W-1:2*SAMPLE_BITS];

   wcrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wcrm_dp #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .ROW_BITS     (ROW_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd           (cmd),
      .stat          (stat),
      .min_sample    (min_sample),
      .max_sample    (max_sample),
      .channel_index (channel_index),
      .last_channel  (req_tlast),
      .row_first     (row_first),
      .row_second    (row_second),
      .row_third     (row_third),
      .row_fourth    (row_fourth),
      .combined_mode (combined_mode)
   );

   assign rsp_tdata = RSP_W'({row_fourth, row_third, row_second, row_first});
   assign rsp_tuser = combined_mode;

   // elaboration check that the request and response fields fit their padded widths
   if (REQ_W < 2*SAMPLE_BITS + CH_W || RSP_W < ROWS_W) begin : g_bad_width
      $error("channel packing does not fit");
   end

endmodule

`default_nettype wire
